@@ sv/websocket_frame_receiver_assert.svh @@
// ---------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define WSFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("websocket_frame_receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define WSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("websocket_frame_receiver: next-cycle check failed");

`endif

@@ sv/wsfr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WebSocket frame receiver package
// Field widths, the length default and the result record.
// ---------------------------------------------------------------------------
package wsfr_pkg;

    localparam int BYTE_W              = 8;
    localparam int OPCODE_W            = 4;
    localparam int LENGTH_BITS_DEFAULT = 32;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic                has_data;
        logic                frame_end;
        logic [OPCODE_W-1:0] opcode;
        logic                fin;
        logic                oversize;
    } res_t;

endpackage

@@ sv/wsfr_byte_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one stream byte per transfer.
// ---------------------------------------------------------------------------
interface wsfr_byte_if;
    import wsfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/wsfr_result_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decoded result channel
// Valid/ready channel carrying one payload byte or end marker per transfer.
// ---------------------------------------------------------------------------
interface wsfr_result_if;
    import wsfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic                has_data;
    logic                frame_end;
    logic [OPCODE_W-1:0] opcode;
    logic                fin;
    logic                oversize;

    modport source (output valid, output data_byte, output has_data, output frame_end,
                    output opcode, output fin, output oversize, input ready);
    modport sink   (input valid, input data_byte, input has_data, input frame_end,
                    input opcode, input fin, input oversize, output ready);
endinterface

@@ sv/wsfr_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WebSocket frame parser
// Header/length/key state machine and payload unmasking, one byte per step.
// ---------------------------------------------------------------------------
module wsfr_parser #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [wsfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                        emit,
    output wsfr_pkg::res_t              result
);
    import wsfr_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_BYTES = 3'd0;   // wraps: eight bytes
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    logic [2:0]             phase_reg,     phase_next;
    logic                   fin_reg,       fin_next;
    logic [OPCODE_W-1:0]    opcode_reg,    opcode_next;
    logic                   masked_reg,    masked_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [2:0]             left_reg,      left_next;
    logic [31:0]            key_reg,       key_next;
    logic [1:0]             key_index_reg, key_index_next;
    logic                   oversize_reg,  oversize_next;

    logic [6:0]             len_code;
    logic [LENGTH_BITS-1:0] shifted_len;
    logic [LENGTH_BITS-1:0] dec_len;
    logic [BYTE_W-1:0]      key_byte;
    logic [BYTE_W-1:0]      data_val;
    logic                   has_val;
    logic                   end_val;

    assign len_code    = rx_byte[6:0];
    assign shifted_len = {remaining_reg[LENGTH_BITS-9:0], rx_byte};
    assign dec_len     = remaining_reg - LENGTH_BITS'(1);
    assign key_byte    = key_reg[{~key_index_reg, 3'b000} +: 8];

    always_comb
    begin
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        remaining_next = remaining_reg;
        left_next      = left_reg;
        key_next       = key_reg;
        key_index_next = key_index_reg;
        oversize_next  = oversize_reg;
        emit           = 1'b0;
        data_val       = '0;
        has_val        = 1'b0;
        end_val        = 1'b0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                masked_next    = rx_byte[7];
                key_next       = '0;
                remaining_next = '0;
                if (len_code == LEN_CODE_16)
                begin
                    left_next  = EXT16_BYTES;
                    phase_next = PH_EXTLEN;
                end
                else if (len_code == LEN_CODE_64)
                begin
                    left_next  = EXT64_BYTES;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    remaining_next = LENGTH_BITS'(len_code);
                    if (rx_byte[7])
                    begin
                        left_next  = KEY_BYTES;
                        phase_next = PH_KEY;
                    end
                    else if (len_code == 7'd0)
                    begin
                        emit       = 1'b1;
                        end_val    = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        key_index_next = '0;
                        phase_next     = PH_PAYLOAD;
                    end
                end
            end

            PH_EXTLEN:
            begin
                if (remaining_reg[LENGTH_BITS-1 -: 8] != '0)
                    oversize_next = 1'b1;
                remaining_next = shifted_len;
                left_next      = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    if (masked_reg)
                    begin
                        left_next  = KEY_BYTES;
                        phase_next = PH_KEY;
                    end
                    else if (shifted_len == '0)
                    begin
                        emit       = 1'b1;
                        end_val    = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        key_index_next = '0;
                        phase_next     = PH_PAYLOAD;
                    end
                end
            end

            PH_KEY:
            begin
                key_next  = {key_reg[23:0], rx_byte};
                left_next = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    if (remaining_reg == '0)
                    begin
                        emit       = 1'b1;
                        end_val    = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        key_index_next = '0;
                        phase_next     = PH_PAYLOAD;
                    end
                end
            end

            PH_PAYLOAD:
            begin
                key_index_next = key_index_reg + 2'd1;
                remaining_next = dec_len;
                emit           = 1'b1;
                has_val        = 1'b1;
                data_val       = rx_byte ^ key_byte;
                end_val        = (dec_len == '0);
                if (dec_len == '0)
                    phase_next = PH_HDR0;
            end

            default:
            begin
                // first header byte; unused codes land here too
                fin_next      = rx_byte[7];
                opcode_next   = rx_byte[OPCODE_W-1:0];
                oversize_next = 1'b0;
                phase_next    = PH_HDR1;
            end
        endcase
    end

    always_comb
    begin
        result.data_byte = data_val;
        result.has_data  = has_val;
        result.frame_end = end_val;
        result.opcode    = opcode_next;
        result.fin       = fin_next;
        result.oversize  = oversize_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            masked_reg    <= 1'b0;
            remaining_reg <= '0;
            left_reg      <= '0;
            key_reg       <= '0;
            key_index_reg <= '0;
            oversize_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            masked_reg    <= masked_next;
            remaining_reg <= remaining_next;
            left_reg      <= left_next;
            key_reg       <= key_next;
            key_index_reg <= key_index_next;
            oversize_reg  <= oversize_next;
        end
    end
endmodule

@@ sv/websocket_frame_receiver.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WebSocket frame receiver
// RFC 6455 receive-side framing: header decode, length, unmasking.
// ---------------------------------------------------------------------------
// Usage:
//   rx     - one received stream byte per transfer (rx_byte).
//   frames - one result per payload byte (has_data = 1, data_byte unmasked),
//            or a single end marker with no data for a zero-length frame.
//            frame_end flags the last result of a frame; opcode, fin and
//            oversize describe the frame the result belongs to.
//   Header, extended length and key bytes produce no result, except the
//   byte that completes the header of an empty frame.
// Timing: a result appears on frames in the cycle after its byte transfers.
// Throughput: one byte per cycle while frames is not stalled. The parser
//   state is updated in the cycle the byte transfers, and the result lands
//   in one output register, so the next byte can follow at once.
// Stall: while a result waits in the output register and frames.ready is
//   low, rx.ready is low; nothing is dropped.
// Reset: rst_n clears the parser to wait for the first header byte and
//   empties the output register.
// LENGTH_BITS sets the payload length counter; a 64-bit length with bits
//   above it flags oversize and keeps its low bits.
// ---------------------------------------------------------------------------
module websocket_frame_receiver #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    wsfr_byte_if.sink     rx,
    wsfr_result_if.source frames
);
    import wsfr_pkg::*;

    logic rx_xfer;       // byte transfer this cycle
    logic emit;          // parser has a result for this byte
    res_t result;        // parser result, combinational
    logic out_valid_reg;
    res_t out_data_reg;  // payload: no reset needed

    // Output slot is free when empty or being drained this cycle.
    assign rx.ready = !out_valid_reg || frames.ready;
    assign rx_xfer  = rx.valid && rx.ready;

    wsfr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (rx_xfer),
        .rx_byte (rx.rx_byte),
        .emit    (emit),
        .result  (result)
    );

    // Output register: load on an emitting byte, clear when drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rx_xfer)
            out_valid_reg <= emit;
        else if (frames.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_xfer && emit)
            out_data_reg <= result;
    end

    assign frames.valid     = out_valid_reg;
    assign frames.data_byte = out_data_reg.data_byte;
    assign frames.has_data  = out_data_reg.has_data;
    assign frames.frame_end = out_data_reg.frame_end;
    assign frames.opcode    = out_data_reg.opcode;
    assign frames.fin       = out_data_reg.fin;
    assign frames.oversize  = out_data_reg.oversize;
endmodule

@@ sv/wsfr_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WebSocket frame receiver port checker
// Port-level checks on backpressure and result encoding, bound to the top.
// ---------------------------------------------------------------------------
`include "websocket_frame_receiver_assert.svh"

module wsfr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rx_valid,
    input logic                          rx_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [wsfr_pkg::BYTE_W-1:0]   res_data_byte,
    input logic                          res_has_data,
    input logic                          res_frame_end,
    input logic [wsfr_pkg::OPCODE_W-1:0] res_opcode,
    input logic                          res_fin,
    input logic                          res_oversize
);
    import wsfr_pkg::*;

    // Input side is held off exactly while a result is stuck.
    `WSFR_ASSERT_IMPLIES(a_rx_backpressure, clk, rst_n, 1'b1, rx_ready == !(res_valid && !res_ready))

    // A result without data is always an end marker, and carries a zero byte.
    `WSFR_ASSERT_IMPLIES(a_empty_is_end, clk, rst_n, res_valid && !res_has_data, res_frame_end && res_data_byte == '0)

    // With no byte accepted and no result drained, valid cannot appear.
    `WSFR_ASSERT_NEXT(a_no_spurious, clk, rst_n, !res_valid && !(rx_valid && rx_ready), !res_valid)

    // A stalled result holds all of its fields.
    `WSFR_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({res_data_byte, res_has_data, res_frame_end, res_opcode, res_fin, res_oversize}))
endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx.valid),
    .rx_ready      (rx.ready),
    .res_valid     (frames.valid),
    .res_ready     (frames.ready),
    .res_data_byte (frames.data_byte),
    .res_has_data  (frames.has_data),
    .res_frame_end (frames.frame_end),
    .res_opcode    (frames.opcode),
    .res_fin       (frames.fin),
    .res_oversize  (frames.oversize)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Streams WebSocket frames into the receiver one byte per transfer. A
// byte-level frame parser in the bench predicts each unmasked payload byte
// and end marker, and every result transfer is checked field by field.
// The test covers directed header cases, random well-formed frames, noise
// with resync, and a long output stall that backs up the input.
// ---------------------------------------------------------------------------
module tb;
    import wsfr_pkg::*;

    localparam int          LEN_W        = LENGTH_BITS_DEFAULT;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_BYTES = 1500;
    localparam int          NOISE_BYTES  = 220;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // Parser phases of the bench's own frame decoder.
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } parse_phase_t;

    // How the payload length is coded in the second header byte.
    typedef enum logic [1:0] {
        LEN_7,
        LEN_16,
        LEN_64
    } len_form_t;

    logic clk;
    logic rst_n;

    wsfr_byte_if   rx_ch ();
    wsfr_result_if res_ch ();

    websocket_frame_receiver #(
        .LENGTH_BITS(LEN_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frames(res_ch)
    );

    // -----------------------------------------------------------------------
    // Frame decoder state, mirrors what the receiver must track
    // -----------------------------------------------------------------------
    parse_phase_t         ph;
    logic                 fin_r;
    logic [OPCODE_W-1:0]  opc_r;
    logic                 mask_r;
    logic [LEN_W-1:0]     remaining;
    logic [2:0]           len_left;
    logic [31:0]          key_r;
    logic [1:0]           key_idx;
    logic                 over_r;

    // Unmasked bytes and end markers still to come out of the receiver.
    res_t decoded_q[$];

    int unsigned n_sent;
    int unsigned n_errors;
    int          burst_left;
    logic        hold_req;

    // -----------------------------------------------------------------------
    // Clock
    // -----------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_errors++;
        if (n_errors <= 40)
            $display("tb: mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    task automatic push_result(input logic [7:0] data, input logic has, input logic last);
        res_t r;
        r.data_byte = data;
        r.has_data  = has;
        r.frame_end = last;
        r.opcode    = opc_r;
        r.fin       = fin_r;
        r.oversize  = over_r;
        decoded_q.push_back(r);
    endtask

    // Length and key known: an empty frame ends right here.
    task automatic header_known();
        if (remaining == '0) begin
            ph = PH_HDR0;
            push_result(8'h00, 1'b0, 1'b1);
        end
        else begin
            key_idx = 2'd0;
            ph      = PH_PAYLOAD;
        end
    endtask

    // Length known: masked frames still need four key bytes.
    task automatic length_known();
        if (mask_r) begin
            len_left = 3'd4;
            ph       = PH_KEY;
        end
        else
            header_known();
    endtask

    // Advance the decoder by one accepted stream byte.
    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] kb;
        case (ph)
            PH_HDR1: begin
                mask_r    = b[7];
                key_r     = '0;
                remaining = '0;
                if (b[6:0] == LEN_CODE_16) begin
                    len_left = 3'd2;
                    ph       = PH_EXTLEN;
                end
                else if (b[6:0] == LEN_CODE_64) begin
                    len_left = 3'd0;    // wraps, so eight bytes follow
                    ph       = PH_EXTLEN;
                end
                else begin
                    remaining = LEN_W'(b[6:0]);
                    length_known();
                end
            end
            PH_EXTLEN: begin
                // any set bit pushed out of the counter flags oversize
                if (remaining[LEN_W-1 -: 8] != 8'h00)
                    over_r = 1'b1;
                remaining = {remaining[LEN_W-9:0], b};
                len_left  = len_left - 3'd1;
                if (len_left == 3'd0)
                    length_known();
            end
            PH_KEY: begin
                key_r    = {key_r[23:0], b};
                len_left = len_left - 3'd1;
                if (len_left == 3'd0)
                    header_known();
            end
            PH_PAYLOAD: begin
                kb        = key_r[8*(3-key_idx) +: 8];
                key_idx   = key_idx + 2'd1;
                remaining = remaining - LEN_W'(1);
                if (remaining == '0)
                    ph = PH_HDR0;
                push_result(b ^ kb, 1'b1, remaining == '0);
            end
            default: begin
                fin_r  = b[7];
                opc_r  = b[3:0];
                over_r = 1'b0;
                ph     = PH_HDR1;
            end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Sender: bursts of back-to-back transfers with random gaps. The byte
    // is parsed on the edge it transfers, so the decoder state is current
    // when the next byte is chosen.
    // -----------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        parse_byte(b);
        n_sent++;
        burst_left--;
    endtask

    // Build one frame and stream it; payload content is random.
    task automatic send_frame(input logic fin_b, input logic [2:0] rsv,
                              input logic [OPCODE_W-1:0] opc, input logic mask_b,
                              input len_form_t form, input logic [31:0] len_hi,
                              input logic [31:0] len, input logic [31:0] mkey);
        logic [7:0]  fb[$];
        logic [63:0] len64;
        fb.push_back({fin_b, rsv, opc});
        case (form)
            LEN_7:
                fb.push_back({mask_b, len[6:0]});
            LEN_16: begin
                fb.push_back({mask_b, LEN_CODE_16});
                fb.push_back(len[15:8]);
                fb.push_back(len[7:0]);
            end
            default: begin
                fb.push_back({mask_b, LEN_CODE_64});
                len64 = {len_hi, len};
                for (int i = 7; i >= 0; i--)
                    fb.push_back(len64[8*i +: 8]);
            end
        endcase
        if (mask_b)
            for (int i = 3; i >= 0; i--)
                fb.push_back(mkey[8*i +: 8]);
        for (int i = 0; i < len; i++)
            fb.push_back(8'($urandom));
        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    // -----------------------------------------------------------------------
    // Result checker: each result transfer is matched against the oldest
    // pending prediction.
    // -----------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (decoded_q.size() == 0)
                report_mismatch("unexpected result, data_byte", 32'h0,
                                32'(res_ch.data_byte));
            else begin
                want = decoded_q.pop_front();
                if (res_ch.data_byte !== want.data_byte)
                    report_mismatch("data_byte", 32'(want.data_byte),
                                    32'(res_ch.data_byte));
                if (res_ch.has_data !== want.has_data)
                    report_mismatch("has_data", 32'(want.has_data),
                                    32'(res_ch.has_data));
                if (res_ch.frame_end !== want.frame_end)
                    report_mismatch("frame_end", 32'(want.frame_end),
                                    32'(res_ch.frame_end));
                if (res_ch.opcode !== want.opcode)
                    report_mismatch("opcode", 32'(want.opcode), 32'(res_ch.opcode));
                if (res_ch.fin !== want.fin)
                    report_mismatch("fin", 32'(want.fin), 32'(res_ch.fin));
                if (res_ch.oversize !== want.oversize)
                    report_mismatch("oversize", 32'(want.oversize),
                                    32'(res_ch.oversize));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall pattern switches to a random mode at intervals counted
    // by tick. A hold request keeps ready low for HOLD_CYCLES, counted here.
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int unsigned tick;
        int          mode;
        logic        rdy;
        tick = 0;
        mode = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                tick++;
                if (tick % 128 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0:       rdy = 1'b1;                       // no stalls
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (tick % 4 == 0);            // one in four
                    default: rdy = ($urandom_range(0, 9) == 0);
                endcase
                res_ch.ready <= rdy;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog
    // -----------------------------------------------------------------------
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Empty frames: end marker with no data, unmasked and after a key.
    // Header with all RSV bits and the top opcode, then an all-zero first header byte.
    task automatic test_empty_frames();
        send_frame(1'b1, 3'b111, 4'hF, 1'b0, LEN_7, 32'h0, 32'd0, 32'h0);
        send_frame(1'b0, 3'b000, 4'h0, 1'b1, LEN_7, 32'h0, 32'd0, 32'hFFFF_FFFF);
    endtask

    // 64-bit length with the top bit and upper half set (oversize, kept to
    // the low bits), and a nonminimal 16-bit length on a masked frame.
    task automatic test_extended_lengths();
        send_frame(1'b1, 3'b000, 4'h2, 1'b0, LEN_64, 32'h8000_0001, 32'd1, 32'h0);
        send_frame(1'b0, 3'b010, 4'h9, 1'b1, LEN_16, 32'h0, 32'd2, 32'h00FF_A55A);
    endtask

    // Output held off while the sender keeps offering a long payload.
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_frame(1'b1, 3'b000, 4'h1, 1'b0, LEN_7, 32'h0, 32'd60, 32'h0);
        wait (!hold_req);
        send_frame(1'b1, 3'b000, 4'h2, 1'b1, LEN_7, 32'h0, 32'd40, $urandom);
    endtask

    // Well-formed frames with random header fields, lengths and keys.
    task automatic test_random_frames();
        logic [31:0] len;
        logic [31:0] hi;
        len_form_t   form;
        int          pick;
        while (n_sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      len = $urandom_range(0, 8);
            else if (pick < 85) len = $urandom_range(9, 40);
            else if (pick < 97) len = $urandom_range(41, 125);
            else                len = $urandom_range(126, 400);
            pick = $urandom_range(0, 99);
            if (len > 125)
                form = (pick < 50) ? LEN_16 : LEN_64;
            else if (pick < 70)
                form = LEN_7;
            else
                form = (pick < 85) ? LEN_16 : LEN_64;
            hi = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h1) : 32'h0;
            send_frame(1'($urandom), 3'($urandom), 4'($urandom),
                       $urandom_range(0, 3) != 0, form, hi, len, $urandom);
        end
    endtask

    // Random bytes, then random bytes until the parser is back at a frame
    // start. Extended length bytes that would end up in the counter are
    // kept low so no payload runs longer than 255 bytes; the bytes that
    // get shifted out stay random and can flag oversize.
    task automatic test_noise();
        logic [7:0] b;
        for (int i = 0; i < NOISE_BYTES || ph != PH_HDR0; i++) begin
            b = 8'($urandom);
            if (ph == PH_EXTLEN && len_left inside {3'd2, 3'd3, 3'd4})
                b = 8'h00;
            send_byte(b);
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        rst_n         = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        hold_req      = 1'b0;
        burst_left    = 0;
        n_sent        = 0;
        n_errors      = 0;
        ph            = PH_HDR0;
        fin_r         = 1'b0;
        opc_r         = '0;
        mask_r        = 1'b0;
        remaining     = '0;
        len_left      = 3'd0;
        key_r         = '0;
        key_idx       = 2'd0;
        over_r        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_frames();
        test_extended_lengths();
        test_backpressure();
        test_random_frames();
        test_noise();

        // drain: wait for the pending results, then wait on for stray results
        rx_ch.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ websocket_frame_receiver.f @@
+incdir+sv
sv/wsfr_pkg.sv
sv/wsfr_byte_if.sv
sv/wsfr_result_if.sv
sv/wsfr_parser.sv
sv/websocket_frame_receiver.sv
sv/wsfr_checker.sv
test/tb.sv
